[hdl/dwr_pkg.sv]
// shared types, codes and sizes for the word recogniser
`timescale 1ns / 1ps
package dwr_pkg;

    // automaton sizes follow the field widths
    localparam int STATE_W     = 5;
    localparam int SYM_W       = 8;
    localparam int STATE_COUNT = 1 << STATE_W;
    localparam int SYMBOL_COUNT = 1 << SYM_W;
    localparam int TBL_DEPTH   = STATE_COUNT * SYMBOL_COUNT;
    localparam int TBL_ADDR_W  = $clog2(TBL_DEPTH);
    // table entry: valid bit on top of the target state
    localparam int ENTRY_W     = STATE_W + 1;

    localparam logic [SYM_W-1:0] EMPTY_SYMBOL = SYM_W'(64);

    // stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SYMBOL = 2'd1,
        CMD_END    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_REJECT  = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_BLOCKED = 2'd2
    } t_verdict;

    typedef enum logic {
        REG_START_STATE = 1'b0,
        REG_ACCEPT_MASK = 1'b1
    } t_reg_idx;

    typedef logic [STATE_W-1:0] t_state;

endpackage

[hdl/dwr_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module dwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/dfa_word_recognizer_unit.sv]
// top level of the word recogniser: table memory, lookup stage and result buffer
// one item per cycle while the skid is empty and no clearing pass runs; a symbol's
// table read returns in the next cycle and is forwarded straight into the next
// symbol's read address; an end-of-word result is registered into the output
// register, or the skid when stalled; after reset a clearing pass writes all 8192
// table entries, one per cycle, input held off; configuration writes taken throughout
`timescale 1ns / 1ps
module dfa_word_recognizer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // from_state [4:0], symbol [12:5], to_state [17:13], entry_valid [18], zero fill
    input  logic [dwr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd [1:0]
    input  logic [dwr_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // verdict [1:0], end_state [6:2], zero fill
    output logic [dwr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dwr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dwr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dwr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import dwr_pkg::*;

    // request fields
    logic                in_acc;
    t_cmd                in_cmd;
    t_state              in_from;
    logic [SYM_W-1:0]    in_sym;
    t_state              in_to;
    logic                in_valid;

    // configuration
    logic                cfg_wr;
    t_reg_idx            cfg_idx;
    t_state              r_start_state;
    logic [31:0]         r_accept_mask;

    // clearing pass
    logic                  r_clearing;
    logic [TBL_ADDR_W-1:0] r_clr_addr;

    // table memory ports
    logic                  ram_we;
    logic [TBL_ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [TBL_ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    // word state and pending lookup
    t_state              r_cur_state, n_cur_state;
    logic                r_blocked, n_blocked;
    logic                r_s1_lookup, n_s1_lookup;
    t_state              eff_state;
    logic                eff_blocked;
    logic                rd_hit;

    // result buffer: output register plus skid
    logic                res_valid;
    logic [OUT_DATA_W-1:0] res_data;
    t_verdict            res_verdict;
    logic                r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                r_k_valid;
    logic [OUT_DATA_W-1:0] r_k_data;

    // unpack the request
    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign in_cmd   = t_cmd'(s_axis_tuser);
    assign in_from  = s_axis_tdata[4:0];
    assign in_sym   = s_axis_tdata[12:5];
    assign in_to    = s_axis_tdata[17:13];
    assign in_valid = s_axis_tdata[18];

    assign s_axis_tready = ~r_clearing & ~r_k_valid;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        unique case (cfg_idx)
            REG_START_STATE: prdata = APB_DATA_W'(r_start_state);
            REG_ACCEPT_MASK: prdata = APB_DATA_W'(r_accept_mask);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_accept_mask <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_START_STATE: r_start_state <= pwdata[STATE_W-1:0];
                REG_ACCEPT_MASK: r_accept_mask <= pwdata[31:0];
                default:         r_accept_mask <= r_accept_mask;
            endcase
        end
    end

    // clearing pass over the table after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == TBL_ADDR_W'(TBL_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // resolve the lookup issued last cycle
    assign rd_hit      = ram_rdata[ENTRY_W-1];
    assign eff_state   = (r_s1_lookup && rd_hit) ? ram_rdata[STATE_W-1:0] : r_cur_state;
    assign eff_blocked = r_blocked | (r_s1_lookup & ~rd_hit);

    // table write port: clearing pass or entry write request
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {in_from, in_sym};
        ram_wdata = in_valid ? {1'b1, in_to} : '0;
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (in_acc && in_cmd == CMD_WRITE) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = {eff_state, in_sym};

    dwr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // word state update and verdict
    always_comb begin
        n_cur_state = eff_state;
        n_blocked   = eff_blocked;
        n_s1_lookup = 1'b0;
        res_valid   = 1'b0;
        if (eff_blocked) begin
            res_verdict = VERDICT_BLOCKED;
        end else if (r_accept_mask[eff_state]) begin
            res_verdict = VERDICT_ACCEPT;
        end else begin
            res_verdict = VERDICT_REJECT;
        end
        if (in_acc) begin
            case (in_cmd)
                CMD_SYMBOL: begin
                    n_s1_lookup = ~eff_blocked & (in_sym != EMPTY_SYMBOL);
                end
                CMD_END: begin
                    res_valid   = 1'b1;
                    n_cur_state = r_start_state;
                    n_blocked   = 1'b0;
                end
                default: begin
                    n_s1_lookup = 1'b0;
                end
            endcase
        end
        // a start state write restarts the word
        if (cfg_wr && cfg_idx == REG_START_STATE) begin
            n_cur_state = pwdata[STATE_W-1:0];
            n_blocked   = 1'b0;
        end
    end

    assign res_data = OUT_DATA_W'({eff_state, res_verdict});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
            r_blocked   <= 1'b0;
            r_s1_lookup <= 1'b0;
        end else begin
            r_cur_state <= n_cur_state;
            r_blocked   <= n_blocked;
            r_s1_lookup <= n_s1_lookup;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_k_valid <= 1'b0;
        end else if (r_m_valid && !m_axis_tready) begin
            if (res_valid) begin
                r_k_valid <= 1'b1;
            end
        end else if (r_k_valid) begin
            r_m_valid <= 1'b1;
            r_k_valid <= 1'b0;
        end else begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m_valid && !m_axis_tready) begin
            if (res_valid) begin
                r_k_data <= res_data;
            end
        end else if (r_k_valid) begin
            r_m_data <= r_k_data;
        end else if (res_valid) begin
            r_m_data <= res_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // checks
    a_no_input_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s_axis_tready)
        else $error("input taken during table clearing");

    a_skid_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k_valid |-> r_m_valid)
        else $error("skid holds a result while output register is empty");

    a_lookup_from_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_lookup |-> $past(in_acc && in_cmd == CMD_SYMBOL))
        else $error("table lookup without a symbol request");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_cmd == CMD_END) |=> r_m_valid)
        else $error("end of word produced no result");

endmodule
